// File: design/dfdc_pkg.sv
// ----------------------------------------------------------------------------
// dfdc_pkg: shared types and constants
// Field widths, parser phase codes, header layout and the result record of
// the datagram deframer and checksum checker.
// ----------------------------------------------------------------------------
`default_nettype none

package dfdc_pkg;

  localparam int BYTE_W  = 8;
  localparam int LIMIT_W = 11;
  localparam int INDEX_W = 10;
  localparam int SEQ_W   = 32;
  localparam int LEN_W   = 32;
  localparam int HCNT_W  = 4;
  localparam int PHASE_W = 3;

  localparam logic [LIMIT_W-1:0] MAX_PAYLOAD   = 11'd1024;
  localparam logic [LIMIT_W-1:0] MAX_PAYLOAD_RESET = 11'd1024;
  localparam logic [HCNT_W-1:0]  HDR_BYTES     = 4'd9;
  localparam logic [HCNT_W-1:0]  SEQ_END       = 4'd5;
  localparam logic [BYTE_W-1:0]  BYTE_MASK     = 8'hFF;

  localparam logic [PHASE_W-1:0] PH_HUNT    = 3'd0;
  localparam logic [PHASE_W-1:0] PH_HEADER  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd2;
  localparam logic [PHASE_W-1:0] PH_CHECK   = 3'd3;

  typedef struct packed {
    logic [BYTE_W-1:0]  payload_byte;
    logic               payload_valid;
    logic [INDEX_W-1:0] payload_index;
    logic               frame_done;
    logic               frame_good;
    logic               length_error;
    logic [SEQ_W-1:0]   sequence_number;
    logic [BYTE_W-1:0]  start_code;
  } res_t;

  function automatic logic [BYTE_W-1:0] add_eac(input logic [BYTE_W-1:0] sum,
                                                input logic [BYTE_W-1:0] b);
    logic [BYTE_W:0] r;
    r = {1'b0, sum} + {1'b0, b};
    return r[BYTE_W-1:0] + {{(BYTE_W-1){1'b0}}, r[BYTE_W]};
  endfunction

endpackage

`default_nettype wire

// File: design/dfdc_in_if.sv
// ----------------------------------------------------------------------------
// dfdc_in_if: received byte channel
// Valid/ready channel carrying one frame byte and its frame start flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface dfdc_in_if;
  logic                        valid;
  logic                        ready;
  logic [dfdc_pkg::BYTE_W-1:0] rx_byte;
  logic                        frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

`default_nettype wire

// File: design/dfdc_out_if.sv
// ----------------------------------------------------------------------------
// dfdc_out_if: result channel
// Valid/ready channel carrying one parse result for each received byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface dfdc_out_if;
  logic                         valid;
  logic                         ready;
  logic [dfdc_pkg::BYTE_W-1:0]  payload_byte;
  logic                         payload_valid;
  logic [dfdc_pkg::INDEX_W-1:0] payload_index;
  logic                         frame_done;
  logic                         frame_good;
  logic                         length_error;
  logic [dfdc_pkg::SEQ_W-1:0]   sequence_number;
  logic [dfdc_pkg::BYTE_W-1:0]  start_code;

  modport source (output valid, output payload_byte, output payload_valid,
                  output payload_index, output frame_done, output frame_good,
                  output length_error, output sequence_number, output start_code,
                  input ready);
  modport sink   (input valid, input payload_byte, input payload_valid,
                  input payload_index, input frame_done, input frame_good,
                  input length_error, input sequence_number, input start_code,
                  output ready);
endinterface

`default_nettype wire

// File: design/dfdc_parser.sv
// ----------------------------------------------------------------------------
// dfdc_parser: frame state and per-byte result
// Holds the parse phase, header fields, counters and running checksum, and
// forms the result for the byte on the input in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dfdc_parser (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_fire,
  input  wire logic [dfdc_pkg::BYTE_W-1:0]  rx_byte,
  input  wire logic                         frame_start,
  input  wire logic                         cfg_we,
  input  wire logic [dfdc_pkg::LIMIT_W-1:0] cfg_data,
  output dfdc_pkg::res_t                    res
);

  logic [dfdc_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [dfdc_pkg::HCNT_W-1:0]  hcnt_r, hcnt_nxt;
  logic [dfdc_pkg::SEQ_W-1:0]   seq_r, seq_nxt;
  logic [dfdc_pkg::LEN_W-1:0]   len_r, len_nxt;
  logic [dfdc_pkg::LIMIT_W-1:0] pcnt_r, pcnt_nxt;
  logic [dfdc_pkg::BYTE_W-1:0]  sum_r, sum_nxt;
  logic [dfdc_pkg::BYTE_W-1:0]  start_r, start_nxt;
  logic [dfdc_pkg::LIMIT_W-1:0] max_payload_r;

  logic [dfdc_pkg::LIMIT_W-1:0] limit;
  logic [dfdc_pkg::HCNT_W-1:0]  hcnt_inc;
  logic [dfdc_pkg::LIMIT_W-1:0] pcnt_inc;

  assign limit    = (max_payload_r > dfdc_pkg::MAX_PAYLOAD) ? dfdc_pkg::MAX_PAYLOAD
                                                            : max_payload_r;
  assign hcnt_inc = hcnt_r + 4'd1;
  assign pcnt_inc = pcnt_r + 11'd1;

  always_comb begin
    phase_nxt = phase_r;
    hcnt_nxt  = hcnt_r;
    seq_nxt   = seq_r;
    len_nxt   = len_r;
    pcnt_nxt  = pcnt_r;
    sum_nxt   = sum_r;
    start_nxt = start_r;
    res       = '0;
    if (frame_start) begin
      start_nxt = rx_byte;
      sum_nxt   = rx_byte;
      hcnt_nxt  = 4'd1;
      seq_nxt   = '0;
      len_nxt   = '0;
      pcnt_nxt  = '0;
      phase_nxt = dfdc_pkg::PH_HEADER;
    end else begin
      unique case (phase_r)
        dfdc_pkg::PH_HEADER: begin
          sum_nxt = dfdc_pkg::add_eac(sum_r, rx_byte);
          if (hcnt_r < dfdc_pkg::SEQ_END) begin
            seq_nxt = {seq_r[dfdc_pkg::SEQ_W-dfdc_pkg::BYTE_W-1:0], rx_byte};
          end else begin
            len_nxt = {len_r[dfdc_pkg::LEN_W-dfdc_pkg::BYTE_W-1:0], rx_byte};
          end
          hcnt_nxt = hcnt_inc;
          if (hcnt_inc >= dfdc_pkg::HDR_BYTES) begin
            if (len_nxt > {{(dfdc_pkg::LEN_W-dfdc_pkg::LIMIT_W){1'b0}}, limit}) begin
              res.length_error = 1'b1;
              phase_nxt        = dfdc_pkg::PH_HUNT;
            end else if (len_nxt == '0) begin
              phase_nxt = dfdc_pkg::PH_CHECK;
            end else begin
              pcnt_nxt  = '0;
              phase_nxt = dfdc_pkg::PH_PAYLOAD;
            end
          end
        end
        dfdc_pkg::PH_PAYLOAD: begin
          sum_nxt           = dfdc_pkg::add_eac(sum_r, rx_byte);
          res.payload_byte  = rx_byte;
          res.payload_valid = 1'b1;
          res.payload_index = pcnt_r[dfdc_pkg::INDEX_W-1:0];
          pcnt_nxt          = pcnt_inc;
          if ({{(dfdc_pkg::LEN_W-dfdc_pkg::LIMIT_W){1'b0}}, pcnt_inc} >= len_r) begin
            phase_nxt = dfdc_pkg::PH_CHECK;
          end
        end
        dfdc_pkg::PH_CHECK: begin
          res.frame_done      = 1'b1;
          res.frame_good      = ((~sum_r) & dfdc_pkg::BYTE_MASK) == rx_byte;
          res.sequence_number = seq_r;
          res.start_code      = start_r;
          phase_nxt           = dfdc_pkg::PH_HUNT;
        end
        default: begin
          phase_nxt = dfdc_pkg::PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= dfdc_pkg::PH_HUNT;
      hcnt_r        <= '0;
      seq_r         <= '0;
      len_r         <= '0;
      pcnt_r        <= '0;
      sum_r         <= '0;
      start_r       <= '0;
      max_payload_r <= dfdc_pkg::MAX_PAYLOAD_RESET;
    end else begin
      if (in_fire) begin
        phase_r <= phase_nxt;
        hcnt_r  <= hcnt_nxt;
        seq_r   <= seq_nxt;
        len_r   <= len_nxt;
        pcnt_r  <= pcnt_nxt;
        sum_r   <= sum_nxt;
        start_r <= start_nxt;
      end
      if (cfg_we) begin
        max_payload_r <= cfg_data;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/dfdc_out_stage.sv
// ----------------------------------------------------------------------------
// dfdc_out_stage: result register
// Holds one result until the receiver takes it; accepts a new one in the
// cycle the held result leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module dfdc_out_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  dfdc_pkg::res_t      res,
  dfdc_out_if.source          out_ch
);

  logic           valid_r;
  dfdc_pkg::res_t res_r;

  assign in_ready = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      res_r <= res;
    end
  end

  assign out_ch.valid           = valid_r;
  assign out_ch.payload_byte    = res_r.payload_byte;
  assign out_ch.payload_valid   = res_r.payload_valid;
  assign out_ch.payload_index   = res_r.payload_index;
  assign out_ch.frame_done      = res_r.frame_done;
  assign out_ch.frame_good      = res_r.frame_good;
  assign out_ch.length_error    = res_r.length_error;
  assign out_ch.sequence_number = res_r.sequence_number;
  assign out_ch.start_code      = res_r.start_code;

endmodule

`default_nettype wire

// File: design/data_frame_deframer_checker.sv
// ----------------------------------------------------------------------------
// data_frame_deframer_checker: datagram deframer and checksum checker
// Parses start code, sequence number, length, payload and checksum byte.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one received byte per transfer with frame_start marking the
//          start code of a datagram. Every input transfer yields exactly one
//          result transfer on out_ch.
//   out_ch reports payload bytes with their index, length_error on the last
//          length byte of an oversized frame, and frame_done/frame_good with
//          the sequence number and start code on the checksum byte.
//   cfg_we/cfg_data write max_payload; write only while the block is idle.
// A result appears in the cycle after its byte transfers.
// Throughput is one byte per cycle while the receiver keeps taking results, set
// by the single result register after the one-pass update of the phase, counters and checksum.
// A stalled receiver holds the result; in_ch.ready stays high while the held
// result is taken in the same cycle, and drops only while it is not.
// Reset clears the parse state to hunting, empties the result register and
// sets max_payload to 1024.
// ----------------------------------------------------------------------------
`default_nettype none

module data_frame_deframer_checker (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  dfdc_in_if.sink                           in_ch,
  dfdc_out_if.source                        out_ch,
  input  wire logic                         cfg_we,
  input  wire logic [dfdc_pkg::LIMIT_W-1:0] cfg_data
);

  dfdc_pkg::res_t res;
  logic           in_ready;

  assign in_ch.ready = in_ready;

  dfdc_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_ch.valid && in_ready),
    .rx_byte     (in_ch.rx_byte),
    .frame_start (in_ch.frame_start),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .res         (res)
  );

  dfdc_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .res      (res),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

// File: design/dfdc_checker.sv
// ----------------------------------------------------------------------------
// dfdc_checker: port-level assertions
// Checks result consistency and handshake behavior seen at the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dfdc_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [dfdc_pkg::BYTE_W-1:0]  payload_byte,
  input wire logic                         payload_valid,
  input wire logic [dfdc_pkg::INDEX_W-1:0] payload_index,
  input wire logic                         frame_done,
  input wire logic                         frame_good,
  input wire logic                         length_error
);

  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled while the result register can take a transfer");

  a_transfer_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted byte produced no result");

  a_good_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && frame_good |-> frame_done)
    else $error("frame_good without frame_done");

  a_kinds_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones({payload_valid, frame_done, length_error}) <= 1)
    else $error("more than one result kind at once");

  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !payload_valid |-> payload_byte == '0 && payload_index == '0)
    else $error("payload fields nonzero without payload_valid");

endmodule

bind data_frame_deframer_checker dfdc_checker u_dfdc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .payload_byte  (out_ch.payload_byte),
  .payload_valid (out_ch.payload_valid),
  .payload_index (out_ch.payload_index),
  .frame_done    (out_ch.frame_done),
  .frame_good    (out_ch.frame_good),
  .length_error  (out_ch.length_error)
);

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: datagram deframer and checksum checker testbench
// Feeds received bytes over the valid/ready input channel, predicts the
// result of every byte with a local parser model and checks each result
// transfer in order. A short table of directed bytes is followed by random
// frames (good, bad checksum, oversized, truncated) and stray bytes under
// several max_payload settings, with random idling on both channels.
// ----------------------------------------------------------------------------

module tb_top;
  import dfdc_pkg::*;

  localparam int        PHASE_ITEMS = 75;
  localparam int        N_PHASES    = 6;
  localparam int        HOLD_CYCLES = 300;
  localparam int        N_DIRECTED  = 25;
  localparam int        BIG_LEN     = 1024;
  localparam int        MAX_REPORTS = 10;
  localparam realtime   RUN_LIMIT   = 20ms;

  typedef struct packed {
    logic              fs;
    logic [BYTE_W-1:0] b;
    logic              typed;
    res_t              want;
  } dir_row_t;

  // field order: byte, valid, index, done, good, length_error, sequence, start
  localparam res_t NO_RES  = '0;
  localparam res_t DONE_FF = {8'h00, 1'b0, 10'd0, 1'b1, 1'b1, 1'b0, 32'd0, 8'hFF};
  localparam res_t LEN_ERR = {8'h00, 1'b0, 10'd0, 1'b0, 1'b0, 1'b1, 32'd0, 8'h00};

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [LIMIT_W-1:0] cfg_data;

  dfdc_in_if  in_ch ();
  dfdc_out_if out_ch ();

  data_frame_deframer_checker i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data)
  );

  // parser model state
  logic [PHASE_W-1:0] p_phase;
  logic [HCNT_W-1:0]  p_hcnt;
  logic [SEQ_W-1:0]   p_seq;
  logic [LEN_W-1:0]   p_len;
  logic [LIMIT_W-1:0] p_pcnt;
  logic [BYTE_W-1:0]  p_sum;
  logic [BYTE_W-1:0]  p_start;
  logic [LIMIT_W-1:0] p_max;

  res_t parse_results_q [$];

  int mismatches    = 0;
  int bytes_sent    = 0;
  int frame_bytes   = 0;
  int frames_closed = 0;
  int good_frames   = 0;
  int len_errors    = 0;
  int payload_seen  = 0;
  int calm_left     = 0;
  bit hold_req      = 1'b0;

  dir_row_t directed_rows [N_DIRECTED] = '{
    {1'b0, 8'hFF, 1'b1, NO_RES},
    {1'b0, 8'h00, 1'b1, NO_RES},
    {1'b1, 8'hFF, 1'b1, NO_RES},
    {1'b0, 8'h00, 1'b1, NO_RES},
    {1'b0, 8'h00, 1'b1, NO_RES},
    {1'b0, 8'h00, 1'b1, NO_RES},
    {1'b0, 8'h00, 1'b1, NO_RES},
    {1'b0, 8'h00, 1'b1, NO_RES},
    {1'b0, 8'h00, 1'b1, NO_RES},
    {1'b0, 8'h00, 1'b1, NO_RES},
    {1'b0, 8'h00, 1'b1, NO_RES},
    {1'b0, 8'h00, 1'b1, DONE_FF},
    {1'b1, 8'h00, 1'b1, NO_RES},
    {1'b0, 8'hFF, 1'b1, NO_RES},
    {1'b0, 8'hFF, 1'b1, NO_RES},
    {1'b0, 8'hFF, 1'b1, NO_RES},
    {1'b0, 8'hFF, 1'b1, NO_RES},
    {1'b0, 8'hFF, 1'b1, NO_RES},
    {1'b0, 8'hFF, 1'b1, NO_RES},
    {1'b0, 8'hFF, 1'b1, NO_RES},
    {1'b0, 8'hFF, 1'b1, LEN_ERR},
    {1'b0, 8'hA5, 1'b1, NO_RES},
    {1'b1, 8'h5A, 1'b0, NO_RES},
    {1'b0, 8'h12, 1'b0, NO_RES},
    {1'b1, 8'h7E, 1'b0, NO_RES}
  };

  function automatic logic [LEN_W-1:0] active_limit();
    return (p_max > MAX_PAYLOAD) ? LEN_W'(MAX_PAYLOAD) : LEN_W'(p_max);
  endfunction

  function automatic res_t deframe_byte(input logic fs, input logic [BYTE_W-1:0] b);
    res_t            r;
    logic [BYTE_W:0] s9;
    r = '0;
    if (fs) begin
      p_start = b;
      p_sum   = b;
      p_hcnt  = 4'd1;
      p_seq   = '0;
      p_len   = '0;
      p_pcnt  = '0;
      p_phase = PH_HEADER;
      return r;
    end
    case (p_phase)
      PH_HEADER: begin
        s9    = {1'b0, p_sum} + {1'b0, b};
        p_sum = s9[BYTE_W-1:0] + BYTE_W'(s9[BYTE_W]);
        if (p_hcnt < SEQ_END) p_seq = {p_seq[SEQ_W-9:0], b};
        else                  p_len = {p_len[LEN_W-9:0], b};
        p_hcnt = p_hcnt + 4'd1;
        if (p_hcnt >= HDR_BYTES) begin
          if (p_len > active_limit()) begin
            r.length_error = 1'b1;
            p_phase        = PH_HUNT;
          end else if (p_len == '0) begin
            p_phase = PH_CHECK;
          end else begin
            p_pcnt  = '0;
            p_phase = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        s9              = {1'b0, p_sum} + {1'b0, b};
        p_sum           = s9[BYTE_W-1:0] + BYTE_W'(s9[BYTE_W]);
        r.payload_byte  = b;
        r.payload_valid = 1'b1;
        r.payload_index = p_pcnt[INDEX_W-1:0];
        p_pcnt          = p_pcnt + 1'b1;
        if (LEN_W'(p_pcnt) >= p_len) p_phase = PH_CHECK;
      end
      PH_CHECK: begin
        r.frame_done      = 1'b1;
        r.frame_good      = ((p_sum ^ BYTE_MASK) == b);
        r.sequence_number = p_seq;
        r.start_code      = p_start;
        p_phase           = PH_HUNT;
      end
      default: p_phase = PH_HUNT;
    endcase
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_byte(input logic fs, input logic [BYTE_W-1:0] b,
                           input logic typed, input res_t want);
    int   gap;
    res_t w;
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 99) < 3) calm_left = $urandom_range(20, 80);
    end
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid       <= 1'b1;
    in_ch.rx_byte     <= b;
    in_ch.frame_start <= fs;
    do @(posedge clk); while (!in_ch.ready);
    if (fs || p_phase != PH_HUNT) frame_bytes++;
    bytes_sent++;
    w = deframe_byte(fs, b);
    if (typed) w = want;
    parse_results_q = {parse_results_q, w};
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (parse_results_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_max_payload(input logic [LIMIT_W-1:0] v);
    drain_results();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    p_max = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_frame(input logic [BYTE_W-1:0] sc, input logic [SEQ_W-1:0] sq,
                            input logic [LEN_W-1:0] ln, input bit good, input bit broken);
    logic [BYTE_W-1:0] fb [$];
    int                cut;
    int                i;
    fb = {fb, sc};
    for (i = 0; i < 4; i++) fb = {fb, sq[31-8*i -: 8]};
    for (i = 0; i < 4; i++) fb = {fb, ln[31-8*i -: 8]};
    if (ln <= active_limit())
      for (i = 0; i < int'(ln); i++) fb = {fb, BYTE_W'($urandom)};
    cut = broken ? $urandom_range(1, fb.size()) : fb.size() + 1;
    for (i = 0; i < fb.size(); i++) begin
      if (i == cut) return;
      push_byte(i == 0, fb[i], 1'b0, NO_RES);
    end
    if (cut > fb.size() && ln <= active_limit())
      push_byte(1'b0, good ? (p_sum ^ BYTE_MASK) : BYTE_W'($urandom), 1'b0, NO_RES);
  endtask

  task automatic random_traffic(input int target);
    int                r;
    int                cap;
    logic [LEN_W-1:0]  lim;
    logic [LEN_W-1:0]  ln;
    while (frame_bytes < target) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        repeat ($urandom_range(1, 4)) push_byte(1'b0, BYTE_W'($urandom), 1'b0, NO_RES);
      end else begin
        lim = active_limit();
        cap = (lim < 12) ? int'(lim) : 12;
        r   = $urandom_range(0, 99);
        if (r < 10)      ln = '0;
        else if (r < 75) ln = (cap == 0) ? '0 : LEN_W'($urandom_range(1, cap));
        else if (r < 83) ln = (lim <= 64) ? lim : LEN_W'($urandom_range(13, 64));
        else if (r < 91) ln = lim + 1;
        else             ln = $urandom;
        send_frame(BYTE_W'($urandom), $urandom, ln, $urandom_range(0, 99) < 60,
                   $urandom_range(0, 99) < 10);
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT);
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin : result_sink
    int left;
    bit rdy;
    out_ch.ready = 1'b0;
    left = 0;
    rdy  = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        rdy      = 1'b0;
        left     = HOLD_CYCLES;
      end else if (left <= 0) begin
        rdy  = !rdy;
        left = rdy ? $urandom_range(1, 40) : pick_gap() + 1;
      end
      out_ch.ready <= rdy;
      left--;
    end
  end

  always @(posedge clk) begin : result_check
    res_t got;
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.payload_byte, out_ch.payload_valid, out_ch.payload_index,
             out_ch.frame_done, out_ch.frame_good, out_ch.length_error,
             out_ch.sequence_number, out_ch.start_code};
      if (got.frame_done) frames_closed++;
      if (got.frame_done && got.frame_good) good_frames++;
      if (got.length_error) len_errors++;
      if (got.payload_valid) payload_seen++;
      if (parse_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("tb_top: result transfer with nothing pending at %0t", $realtime);
      end else begin
        want = parse_results_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("tb_top: mismatch at %0t", $realtime);
            $display("  exp byte=%02h pv=%0b idx=%0d done=%0b good=%0b lerr=%0b seq=%08h sc=%02h",
                     want.payload_byte, want.payload_valid, want.payload_index,
                     want.frame_done, want.frame_good, want.length_error,
                     want.sequence_number, want.start_code);
            $display("  got byte=%02h pv=%0b idx=%0d done=%0b good=%0b lerr=%0b seq=%08h sc=%02h",
                     got.payload_byte, got.payload_valid, got.payload_index,
                     got.frame_done, got.frame_good, got.length_error,
                     got.sequence_number, got.start_code);
          end
        end
      end
    end
  end

  initial begin : stimulus
    logic [LIMIT_W-1:0] settings [N_PHASES];
    int                 ph;
    int                 k;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.rx_byte     = '0;
    in_ch.frame_start = 1'b0;
    p_phase           = PH_HUNT;
    p_hcnt            = '0;
    p_seq             = '0;
    p_len             = '0;
    p_pcnt            = '0;
    p_sum             = '0;
    p_start           = '0;
    p_max             = MAX_PAYLOAD_RESET;
    settings = '{11'd0, 11'd1, 11'd2047, 11'd6, 11'd1024, 11'd0};
    settings[N_PHASES-1] = LIMIT_W'($urandom_range(0, 2047));
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < N_DIRECTED; k++)
      push_byte(directed_rows[k].fs, directed_rows[k].b, directed_rows[k].typed,
                directed_rows[k].want);

    for (ph = 0; ph < N_PHASES; ph++) begin
      write_max_payload(settings[ph]);
      if (ph == 2) hold_req = 1'b1;
      if (settings[ph] == MAX_PAYLOAD)
        send_frame(BYTE_W'($urandom), $urandom, LEN_W'(BIG_LEN), 1'b1, 1'b0);
      random_traffic(frame_bytes + PHASE_ITEMS);
    end

    drain_results();
    $display("tb_top: %0d bytes sent (%0d inside frames) over %0d max_payload settings",
             bytes_sent, frame_bytes, N_PHASES);
    $display("tb_top: %0d frames closed, %0d good, %0d length errors, %0d payload bytes",
             frames_closed, good_frames, len_errors, payload_seen);
    if (mismatches == 0 && parse_results_q.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/dfdc_pkg.sv
design/dfdc_in_if.sv
design/dfdc_out_if.sv
design/dfdc_parser.sv
design/dfdc_out_stage.sv
design/data_frame_deframer_checker.sv
design/dfdc_checker.sv
tb/tb_top.sv
